// ----- rtl/pes_pkg.sv -----
// ----------------------------------------------------------------------------
// pes_pkg: shared types and constants for the six-frame peptide search
// Base and residue codes, the standard codon table and the per-cell control
// bundle that the configuration decoder hands to each codon cell.
// ----------------------------------------------------------------------------
package pes_pkg;

  localparam int MAX_RES   = 24;
  localparam int WIN_DEPTH = 3 * MAX_RES;
  localparam int RES_W     = 5;
  localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
  localparam int RIDX_W    = $clog2(MAX_RES);
  localparam int LEN_W     = 5;
  localparam int POS_W     = 32;

  typedef logic [1:0]       base_t;
  typedef logic [RES_W-1:0] residue_t;

  localparam residue_t STOP_RES = 5'd0;

  typedef enum logic [1:0] {
    CFG_PEPTIDE_LENGTH = 2'd0,
    CFG_WORD_LOW       = 2'd1,
    CFG_WORD_HIGH      = 2'd2
  } cfg_index_t;

  typedef struct packed {
    residue_t want_fwd;
    residue_t want_rev;
    logic     need_fwd;
    logic     need_rev;
  } cell_ctl_t;

  // index 16*b1 + 4*b2 + b3, A0 C1 G2 T3
  localparam residue_t CODON_TABLE [64] = '{
    5'd17, 5'd16, 5'd17, 5'd16, 5'd18, 5'd18, 5'd18, 5'd18,
    5'd4,  5'd12, 5'd4,  5'd12, 5'd19, 5'd19, 5'd20, 5'd19,
    5'd2,  5'd1,  5'd2,  5'd1,  5'd3,  5'd3,  5'd3,  5'd3,
    5'd4,  5'd4,  5'd4,  5'd4,  5'd5,  5'd5,  5'd5,  5'd5,
    5'd7,  5'd6,  5'd7,  5'd6,  5'd8,  5'd8,  5'd8,  5'd8,
    5'd9,  5'd9,  5'd9,  5'd9,  5'd10, 5'd10, 5'd10, 5'd10,
    5'd0,  5'd11, 5'd0,  5'd11, 5'd12, 5'd12, 5'd12, 5'd12,
    5'd0,  5'd13, 5'd14, 5'd13, 5'd5,  5'd15, 5'd5,  5'd15
  };

  function automatic residue_t codon_aa(input base_t b1, input base_t b2, input base_t b3);
    return CODON_TABLE[{b1, b2, b3}];
  endfunction

endpackage

// ----- rtl/six_frame_peptide_encoding_search.sv -----
// ----------------------------------------------------------------------------
// six_frame_peptide_encoding_search: streaming six-frame peptide search
// Input stream: one base per transfer, in_tdata[1:0] the base code and
// in_tuser the first-base flag that restarts position and window fill.
// Output stream: one transfer per window whose forward read or reverse
// complement encodes the configured peptide; out_tdata holds the start
// position and the two hit flags. Windows without a hit give no transfer.
// Configuration: cfg_wr_en, cfg_addr and cfg_wdata write the peptide length
// and the two residue words; write them only while the stream is idle.
// Throughput: one base per cycle while no offered result stalls. A chain of 24 codon cells shifts the
// window one base per transfer and decodes every codon in parallel.
// Result path: after its last base transfers, a result passes a registered
// codon compare, then a reduction into the output register.
// Reset: fill and position clear, length is one, residue words are zero.
// When the receiver stalls on an offered result the whole pipeline holds
// and in_tready drops; in_tready stays high while the output register is
// empty or being taken.
// ----------------------------------------------------------------------------
module six_frame_peptide_encoding_search (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [1:0] nucleotide, [7:2] zero
  input  logic        in_tuser,   // [0] first_base
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] start_position, [32] forward_hit,
                                  // [33] reverse_hit, [39:34] zero
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [59:0] cfg_wdata
);

  localparam int NC = pes_pkg::MAX_RES;

  pes_pkg::cell_ctl_t [NC-1:0]        cell_ctl;
  logic [pes_pkg::FILL_W-1:0]         len3;
  pes_pkg::base_t                     chain [NC+1];
  logic [NC-1:0]                      fwd_ok, rev_ok;

  logic                               adv;
  logic                               in_xfer;

  logic [pes_pkg::FILL_W-1:0]         fill_r, fill_nxt;
  logic [pes_pkg::POS_W-1:0]          pos_r, pos_nxt, idx;

  logic                               s1_valid_r, s2_valid_r;
  logic [pes_pkg::POS_W-1:0]          s1_start_r, s2_start_r;

  logic                               out_valid_r;
  logic [pes_pkg::POS_W-1:0]          out_start_r;
  logic                               out_fwd_r, out_rev_r;
  logic                               hit_fwd, hit_rev;

  pes_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cell_ctl  (cell_ctl),
    .len3      (len3)
  );

  assign adv       = ~out_valid_r | out_tready;
  assign in_tready = adv;
  assign in_xfer   = in_tvalid & adv;
  assign chain[0]  = in_tdata[1:0];

  for (genvar j = 0; j < NC; j++) begin : g_cell
    pes_cell u_cell (
      .clk      (clk),
      .shift_en (in_xfer),
      .adv_en   (adv),
      .base_in  (chain[j]),
      .ctl      (cell_ctl[j]),
      .base_out (chain[j+1]),
      .fwd_ok_r (fwd_ok[j]),
      .rev_ok_r (rev_ok[j])
    );
  end

  always_comb begin
    idx      = in_tuser ? '0 : pos_r;
    pos_nxt  = (idx == '1) ? idx : idx + pes_pkg::POS_W'(1);
    fill_nxt = in_tuser ? pes_pkg::FILL_W'(1) :
               (fill_r == pes_pkg::FILL_W'(pes_pkg::WIN_DEPTH)) ? fill_r :
               fill_r + pes_pkg::FILL_W'(1);
  end

  assign hit_fwd = &fwd_ok;
  assign hit_rev = &rev_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      pos_r       <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      if (in_tvalid) begin
        fill_r <= fill_nxt;
        pos_r  <= pos_nxt;
      end
      s1_valid_r  <= in_tvalid & (fill_nxt >= len3);
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r & (hit_fwd | hit_rev);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_start_r  <= idx - pes_pkg::POS_W'(len3 - pes_pkg::FILL_W'(1));
      s2_start_r  <= s1_start_r;
      out_start_r <= s2_start_r;
      out_fwd_r   <= hit_fwd;
      out_rev_r   <= hit_rev;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_rev_r, out_fwd_r, out_start_r};

  a_hit_flag : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_fwd_r | out_rev_r))
    else $error("result offered without a hit flag");

  a_ready : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r & ~out_tready) |-> ~in_tready)
    else $error("input taken while result stalls");

  a_restart : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid & in_tready & in_tuser) |=> (fill_r == pes_pkg::FILL_W'(1)))
    else $error("first base did not restart window fill");

  a_fill_max : assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= pes_pkg::FILL_W'(pes_pkg::WIN_DEPTH))
    else $error("window fill beyond depth");

endmodule

// ----- rtl/pes_cfg.sv -----
// ----------------------------------------------------------------------------
// pes_cfg: configuration registers and per-cell decode
// Holds the peptide length and residue words, clamps the length and works
// out for each codon cell which residue it must match in either direction.
// ----------------------------------------------------------------------------
module pes_cfg (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_wr_en,
  input  logic [1:0]                              cfg_addr,
  input  logic [59:0]                             cfg_wdata,
  output pes_pkg::cell_ctl_t [pes_pkg::MAX_RES-1:0] cell_ctl,
  output logic [pes_pkg::FILL_W-1:0]              len3
);

  logic [pes_pkg::LEN_W-1:0] len_r;
  logic [59:0]               word_lo_r;
  logic [59:0]               word_hi_r;

  logic [119:0]              word;
  pes_pkg::residue_t         res [pes_pkg::MAX_RES];
  logic [pes_pkg::MAX_RES:0] zero_before;
  logic [pes_pkg::LEN_W-1:0] n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= pes_pkg::LEN_W'(1);
      word_lo_r <= '0;
      word_hi_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        pes_pkg::CFG_PEPTIDE_LENGTH: len_r     <= cfg_wdata[pes_pkg::LEN_W-1:0];
        pes_pkg::CFG_WORD_LOW:       word_lo_r <= cfg_wdata;
        pes_pkg::CFG_WORD_HIGH:      word_hi_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (len_r == '0) begin
      n = pes_pkg::LEN_W'(1);
    end else if (len_r > pes_pkg::LEN_W'(pes_pkg::MAX_RES)) begin
      n = pes_pkg::LEN_W'(pes_pkg::MAX_RES);
    end else begin
      n = len_r;
    end
  end

  assign len3 = pes_pkg::FILL_W'(n) * pes_pkg::FILL_W'(3);
  assign word = {word_hi_r, word_lo_r};

  always_comb begin
    zero_before[0] = 1'b0;
    for (int i = 0; i < pes_pkg::MAX_RES; i++) begin
      res[i]           = word[pes_pkg::RES_W*i +: pes_pkg::RES_W];
      zero_before[i+1] = zero_before[i] | (res[i] == pes_pkg::STOP_RES);
    end
  end

  // cell j holds forward residue n-1-j and reverse residue j
  always_comb begin
    logic                        in_len;
    logic [pes_pkg::RIDX_W-1:0]  fi;
    for (int j = 0; j < pes_pkg::MAX_RES; j++) begin
      in_len = pes_pkg::LEN_W'(j) < n;
      fi     = in_len ? pes_pkg::RIDX_W'(n - pes_pkg::LEN_W'(1) - pes_pkg::LEN_W'(j)) : '0;
      cell_ctl[j].want_fwd = res[fi];
      cell_ctl[j].need_fwd = in_len & ~zero_before[fi];
      cell_ctl[j].want_rev = res[j];
      cell_ctl[j].need_rev = in_len & ~zero_before[j];
    end
  end

endmodule

// ----- rtl/pes_cell.sv -----
// ----------------------------------------------------------------------------
// pes_cell: one codon cell of the base window
// Holds three consecutive bases, passes the oldest on to its neighbor and
// registers whether its codon matches the wanted residue in each direction.
// ----------------------------------------------------------------------------
module pes_cell (
  input  logic               clk,
  input  logic               shift_en,
  input  logic               adv_en,
  input  pes_pkg::base_t     base_in,
  input  pes_pkg::cell_ctl_t ctl,
  output pes_pkg::base_t     base_out,
  output logic               fwd_ok_r,
  output logic               rev_ok_r
);

  pes_pkg::base_t    b0_r, b1_r, b2_r;
  pes_pkg::residue_t aa_fwd, aa_rev;
  logic              fwd_ok_nxt, rev_ok_nxt;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      b0_r <= base_in;
      b1_r <= b0_r;
      b2_r <= b1_r;
    end
  end

  assign base_out = b2_r;

  // b0 is the newest base; reverse complement reads from the newest end
  assign aa_fwd     = pes_pkg::codon_aa(b2_r, b1_r, b0_r);
  assign aa_rev     = pes_pkg::codon_aa(~b0_r, ~b1_r, ~b2_r);
  assign fwd_ok_nxt = ~ctl.need_fwd | (aa_fwd == ctl.want_fwd);
  assign rev_ok_nxt = ~ctl.need_rev | (aa_rev == ctl.want_rev);

  always_ff @(posedge clk) begin
    if (adv_en) begin
      fwd_ok_r <= fwd_ok_nxt;
      rev_ok_r <= rev_ok_nxt;
    end
  end

endmodule
